@@ src/lcp_pkg.sv @@
// lcp_pkg: shared sizes, request/response types and cell control types
// for the lfu cache; no dependencies
package lcp_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int COUNT_BITS  = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int FILL_W      = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W       = 5;
    localparam int CMP_W       = (FILL_W > CAP_W) ? FILL_W : CAP_W;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] key;
        logic [31:0] value;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
        logic        evicted;
        logic [31:0] evicted_key;
    } rsp_t;

    // per-cell write controls
    typedef struct packed {
        logic bump;
        logic load;
        logic wr_value;
    } cell_cmd_t;

    // running victim candidate passed along the chain
    typedef struct packed {
        logic                  found;
        logic [IDX_W-1:0]      idx;
        logic [COUNT_BITS-1:0] cnt;
        logic [31:0]           age;
    } best_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_EVICT
    } state_t;

endpackage

@@ src/lcp_cell.sv @@
// lcp_cell: one cache entry with its key match and one victim-chain stage
// depends on lcp_pkg
module lcp_cell
    import lcp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] cell_idx,
    input  cell_cmd_t        cmd,
    input  logic [31:0]      key_in,
    input  logic [31:0]      value_in,
    input  logic [31:0]      touch_clock,
    input  best_t            best_in,
    output logic             valid,
    output logic             match,
    output logic [31:0]      key,
    output logic [31:0]      value,
    output best_t            best_out
);

    logic                  valid_reg;
    logic [31:0]           key_reg;
    logic [31:0]           value_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [31:0]           last_reg;
    best_t                 best_reg;
    best_t                 best_next;
    logic [31:0]           age;
    logic                  better;

    assign valid    = valid_reg;
    assign key      = key_reg;
    assign value    = value_reg;
    assign match    = valid_reg && (key_reg == key_in);
    assign best_out = best_reg;

    // victim chain stage: lower index keeps ties
    assign age    = touch_clock - last_reg;
    assign better = valid_reg && (!best_in.found || (count_reg < best_in.cnt) ||
                    ((count_reg == best_in.cnt) && (age > best_in.age)));

    always_comb
    begin
        best_next = best_in;
        if (better)
        begin
            best_next.found = 1'b1;
            best_next.idx   = cell_idx;
            best_next.cnt   = count_reg;
            best_next.age   = age;
        end
    end

    // control state and chain stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            best_reg  <= '0;
        end
        else
        begin
            if (cmd.load)
                valid_reg <= 1'b1;
            best_reg <= best_next;
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg   <= key_in;
            value_reg <= value_in;
            count_reg <= COUNT_BITS'(1);
            last_reg  <= touch_clock;
        end
        else
        begin
            if (cmd.wr_value)
                value_reg <= value_in;
            if (cmd.bump)
            begin
                if (count_reg != {COUNT_BITS{1'b1}})
                    count_reg <= count_reg + COUNT_BITS'(1);
                last_reg <= touch_clock;
            end
        end
    end

endmodule

@@ src/lfu_cache_policy.sv @@
// lfu_cache_policy: top level, fsm, hit/free select and the row of cells
// depends on lcp_pkg and lcp_cell
//
//  channel | dir | handshake            | payload
//  in      | in  | in_valid / in_ready  | in_data  (req_t)
//  out     | out | out_valid/ out_ready | out_data (rsp_t)
//  cfg     | in  | cfg_valid/ cfg_ready | cfg_data (capacity)
//
// a get, a put hit, a fill or a put with capacity zero is accepted in idle, then
// looked up in all cells at once; a put miss on a full cache adds a scan while
// the victim ripples down the cell chain, then an evict state.
// reset clears valid bits, fill level and touch clock; no clearing pass.
// a stalled output holds its result and the next request waits behind it.
module lfu_cache_policy
    import lcp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  req_t             in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output rsp_t             out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

    state_t            state_reg, state_next;
    req_t              req_reg;
    rsp_t              out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    logic [CAP_W-1:0]  cap_reg;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [31:0]       tc_reg;
    logic              tc_inc;
    logic [IDX_W-1:0]  scan_reg, scan_next;

    cell_cmd_t   cmd   [MAX_ENTRIES];
    logic        valid [MAX_ENTRIES];
    logic        match [MAX_ENTRIES];
    logic [31:0] keys  [MAX_ENTRIES];
    logic [31:0] vals  [MAX_ENTRIES];
    best_t       chain [MAX_ENTRIES+1];

    logic             hit_any, free_any;
    logic [IDX_W-1:0] hit_idx, free_idx, tgt_idx;
    logic             out_free;
    logic [CMP_W-1:0] cap_wide, cap_eff, fill_wide;
    logic             do_bump, do_load, do_wrv;
    best_t            victim;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // effective capacity
    assign cap_wide  = CMP_W'(cap_reg);
    assign fill_wide = CMP_W'(fill_reg);
    assign cap_eff   = (cap_wide > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : cap_wide;

    // first matching slot and first free slot
    always_comb
    begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!valid[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    // row of cells with the victim chain
    assign chain[0] = '0;
    assign victim   = chain[MAX_ENTRIES];

    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_cell
        always_comb
        begin
            cmd[g].bump     = do_bump && (tgt_idx == IDX_W'(g));
            cmd[g].load     = do_load && (tgt_idx == IDX_W'(g));
            cmd[g].wr_value = do_wrv  && (tgt_idx == IDX_W'(g));
        end

        lcp_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cell_idx    (IDX_W'(g)),
            .cmd         (cmd[g]),
            .key_in      (req_reg.key),
            .value_in    (req_reg.value),
            .touch_clock (tc_reg),
            .best_in     (chain[g]),
            .valid       (valid[g]),
            .match       (match[g]),
            .key         (keys[g]),
            .value       (vals[g]),
            .best_out    (chain[g+1])
        );
    end

    // next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        fill_next      = fill_reg;
        scan_next      = scan_reg;
        do_bump        = 1'b0;
        do_load        = 1'b0;
        do_wrv         = 1'b0;
        tc_inc         = 1'b0;
        tgt_idx        = hit_idx;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_LOOK;
            end
            S_LOOK:
            begin
                if (hit_any || req_reg.opcode == OP_GET || cap_eff == '0 ||
                    (fill_wide < cap_eff && free_any))
                begin
                    if (out_free)
                    begin
                        out_next       = '0;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                        if (hit_any)
                        begin
                            out_next.hit = 1'b1;
                            if (req_reg.opcode == OP_GET)
                                out_next.read_value = vals[hit_idx];
                            else
                                do_wrv = 1'b1;
                            do_bump = 1'b1;
                            tc_inc  = 1'b1;
                        end
                        else if (req_reg.opcode == OP_PUT && cap_eff != '0)
                        begin
                            tgt_idx   = free_idx;
                            do_load   = 1'b1;
                            tc_inc    = 1'b1;
                            fill_next = fill_reg + FILL_W'(1);
                        end
                    end
                end
                else
                begin
                    scan_next  = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                scan_next = scan_reg + IDX_W'(1);
                if (scan_reg == IDX_W'(MAX_ENTRIES - 1))
                    state_next = S_EVICT;
            end
            S_EVICT:
            begin
                if (out_free)
                begin
                    out_next       = '0;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (victim.found)
                    begin
                        out_next.evicted     = 1'b1;
                        out_next.evicted_key = keys[victim.idx];
                        tgt_idx              = victim.idx;
                        do_load              = 1'b1;
                        tc_inc               = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cap_reg       <= '0;
            fill_reg      <= '0;
            tc_reg        <= '0;
            scan_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            fill_reg      <= fill_next;
            scan_reg      <= scan_next;
            if (tc_inc)
                tc_reg <= tc_reg + 32'd1;
            if (cfg_valid)
                cap_reg <= cfg_data;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            req_reg <= in_data;
        out_reg <= out_next;
    end

endmodule

@@ src/lcp_checker.sv @@
// lcp_checker: port-level assertions on the lfu cache top level
// depends on lcp_pkg; bound to lfu_cache_policy
module lcp_checker
    import lcp_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input rsp_t out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // one request at a time
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    // eviction only on a miss
    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.evicted |-> !out_data.hit)
        else $error("eviction on a hit");

    // read data zero on a miss
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hit |-> out_data.read_value == 32'd0)
        else $error("read data on a miss");

    // evicted key zero without eviction
    a_evk_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.evicted |-> out_data.evicted_key == 32'd0)
        else $error("evicted key without eviction");

endmodule

bind lfu_cache_policy lcp_checker u_lcp_checker (.*);

@@ tb/sv/tb_lfu_cache_policy.sv @@
// tb_lfu_cache_policy: self-checking testbench for the lfu cache policy block
// depends on lcp_pkg and lfu_cache_policy; a directed table then random requests,
// checked against an in-bench model of the cache
`timescale 1ns / 100ps

module tb_lfu_cache_policy;
    import lcp_pkg::*;

    localparam int COUNT_MAX  = (1 << COUNT_BITS) - 1;
    localparam int N_RANDOM   = 1750;
    localparam int N_DIRECTED = 20;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    req_t             in_data;
    logic             out_valid;
    logic             out_ready;
    rsp_t             out_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data;

    lfu_cache_policy dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // shadow copy of the cache contents
    logic [CAP_W-1:0]      cap_reg;
    logic                  sh_valid [MAX_ENTRIES];
    logic [31:0]           sh_key   [MAX_ENTRIES];
    logic [31:0]           sh_value [MAX_ENTRIES];
    logic [COUNT_BITS-1:0] sh_count [MAX_ENTRIES];
    logic [31:0]           sh_touch [MAX_ENTRIES];
    logic [31:0]           sh_clock;
    int                    sh_fill;

    rsp_t rsp_queue[$];
    int   fail_count;
    bit   stim_done;
    bit   long_stall;
    bit   no_idle;

    // directed table; expected result given only for the easy rows
    typedef struct {
        req_t req;
        bit   has_exp;
        rsp_t exp;
    } row_t;
    row_t dir_rows[N_DIRECTED];

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // bump use count and recency of one slot
    function automatic void touch_slot(input int s);
        if (sh_count[s] != COUNT_MAX[COUNT_BITS-1:0])
            sh_count[s] = sh_count[s] + 1'b1;
        sh_touch[s] = sh_clock;
        sh_clock    = sh_clock + 1;
    endfunction

    // work out the response of one request and update the shadow state
    function automatic rsp_t cache_access(input req_t r);
        rsp_t        o;
        int          found;
        int          slot;
        int          cap;
        int          best;
        logic [31:0] age;
        logic [31:0] best_age;
        logic [COUNT_BITS-1:0] best_cnt;
        o        = '0;
        found    = -1;
        slot     = -1;
        best     = -1;
        best_age = '0;
        best_cnt = '0;
        cap      = (cap_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap_reg);
        for (int s = 0; s < MAX_ENTRIES; s++)
            if (found < 0 && sh_valid[s] && sh_key[s] == r.key)
                found = s;
        if (found >= 0)
        begin
            o.hit = 1'b1;
            if (r.opcode == OP_GET)
                o.read_value = sh_value[found];
            else
                sh_value[found] = r.value;
            touch_slot(found);
        end
        else if (r.opcode == OP_PUT && cap > 0)
        begin
            if (sh_fill < cap)
            begin
                for (int s = 0; s < MAX_ENTRIES; s++)
                    if (slot < 0 && !sh_valid[s])
                        slot = s;
                if (slot >= 0)
                    sh_fill++;
            end
            if (slot < 0)
            begin
                // least count, then oldest, then lowest index
                for (int s = 0; s < MAX_ENTRIES; s++)
                begin
                    if (!sh_valid[s])
                        continue;
                    age = sh_clock - sh_touch[s];
                    if (best < 0 || sh_count[s] < best_cnt ||
                        (sh_count[s] == best_cnt && age > best_age))
                    begin
                        best     = s;
                        best_cnt = sh_count[s];
                        best_age = age;
                    end
                end
                slot = best;
                if (slot >= 0)
                begin
                    o.evicted     = 1'b1;
                    o.evicted_key = sh_key[slot];
                end
            end
            if (slot >= 0)
            begin
                sh_valid[slot] = 1'b1;
                sh_key[slot]   = r.key;
                sh_value[slot] = r.value;
                sh_count[slot] = '0;
                touch_slot(slot);
            end
        end
        return o;
    endfunction

    // random idle decision, off during the no-idle stretch
    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < 15);
    endfunction

    // send one request and queue its prediction; valid stays up for the next one
    task automatic send_req(input req_t r, input bit has_exp, input rsp_t exp);
        rsp_t p;
        while (idle_now())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        p = cache_access(r);
        if (has_exp && p !== exp)
        begin
            $error("directed row: table %h, model %h", exp, p);
            fail_count++;
        end
        rsp_queue.push_back(has_exp ? exp : p);
        @(negedge clk);
    endtask

    // write capacity once the block has drained
    task automatic set_capacity(input logic [CAP_W-1:0] c);
        in_valid <= 1'b0;
        while (rsp_queue.size() != 0)
            @(negedge clk);
        repeat (MAX_ENTRIES + 8)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= c;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cap_reg = c;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random key from a small pool so hits and evictions are common
    function automatic logic [31:0] pick_key(input int pool);
        int k;
        k = $urandom_range(99);
        if (k < 3)
            return 32'hFFFF_FFFF;
        if (k < 6)
            return $urandom();
        return 32'h0 + $urandom_range(pool) * 32'h0101_0101 ^ ($urandom_range(1) << 31);
    endfunction

    // receiver: random stalls plus one long hold-off
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_stall)
                out_ready <= 1'b0;
            else
                out_ready <= !idle_now();
        end
    end

    // compare each response with the oldest prediction
    always @(posedge clk)
    begin
        rsp_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (rsp_queue.size() == 0)
            begin
                $error("response with nothing expected: %h", out_data);
                fail_count++;
            end
            else
            begin
                e = rsp_queue.pop_front();
                if (out_data.hit !== e.hit)
                begin
                    $error("hit: expected %h actual %h", e.hit, out_data.hit);
                    fail_count++;
                end
                if (out_data.read_value !== e.read_value)
                begin
                    $error("read_value: expected %h actual %h",
                           e.read_value, out_data.read_value);
                    fail_count++;
                end
                if (out_data.evicted !== e.evicted)
                begin
                    $error("evicted: expected %h actual %h", e.evicted, out_data.evicted);
                    fail_count++;
                end
                if (out_data.evicted_key !== e.evicted_key)
                begin
                    $error("evicted_key: expected %h actual %h",
                           e.evicted_key, out_data.evicted_key);
                    fail_count++;
                end
            end
        end
    end

    // long receiver hold-off, counted in cycles
    initial
    begin
        long_stall = 1'b0;
        wait (stim_done == 1'b0 && rst_n);
        repeat (3000)
            @(negedge clk);
        long_stall = 1'b1;
        repeat (200)
            @(negedge clk);
        long_stall = 1'b0;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("lfu_cache_policy test failed");
        $finish;
    end

    // stimulus
    initial
    begin
        req_t r;
        rsp_t z;
        int   caps[6];
        z          = '0;
        fail_count = 0;
        stim_done  = 1'b0;
        no_idle    = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        cap_reg    = '0;
        sh_clock   = '0;
        sh_fill    = 0;
        for (int s = 0; s < MAX_ENTRIES; s++)
        begin
            sh_valid[s] = 1'b0;
            sh_key[s]   = '0;
            sh_value[s] = '0;
            sh_count[s] = '0;
            sh_touch[s] = '0;
        end
        repeat (3)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // after reset, capacity zero: puts store nothing
        dir_rows[0] = '{'{OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1, z};
        dir_rows[1] = '{'{OP_GET, 32'hFFFF_FFFF, 32'h0}, 1, z};
        dir_rows[2] = '{'{OP_PUT, 32'h0, 32'h0}, 1, z};
        for (int i = 0; i < 3; i++)
            send_req(dir_rows[i].req, dir_rows[i].has_exp, dir_rows[i].exp);

        // capacity 2: fill, hit and least-count eviction
        set_capacity(5'd2);
        dir_rows[3]  = '{'{OP_PUT, 32'h0, 32'hFFFF_FFFF}, 1, z};
        dir_rows[4]  = '{'{OP_PUT, 32'hFFFF_FFFF, 32'h1}, 1, z};
        dir_rows[5]  = '{'{OP_GET, 32'h0, 32'h0}, 1, '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}};
        dir_rows[6]  = '{'{OP_PUT, 32'h5, 32'h5}, 1, '{1'b0, 32'h0, 1'b1, 32'hFFFF_FFFF}};
        dir_rows[7]  = '{'{OP_PUT, 32'h5, 32'h6}, 1, '{1'b1, 32'h0, 1'b0, 32'h0}};
        dir_rows[8]  = '{'{OP_GET, 32'h5, 32'hFFFF_FFFF}, 0, z};
        dir_rows[9]  = '{'{OP_PUT, 32'h7, 32'h7}, 0, z};
        dir_rows[10] = '{'{OP_GET, 32'h1234, 32'h0}, 1, z};
        for (int i = 3; i < 11; i++)
            send_req(dir_rows[i].req, dir_rows[i].has_exp, dir_rows[i].exp);

        // capacity above the number of slots saturates; fill all sixteen slots, then evict
        set_capacity(5'd31);
        for (int i = 11; i < N_DIRECTED; i++)
            dir_rows[i] = '{'{OP_PUT, 32'h100 + i, 32'h200 + i}, 0, z};
        for (int i = 11; i < N_DIRECTED; i++)
            send_req(dir_rows[i].req, 0, z);
        for (int i = 0; i < 10; i++)
        begin
            r = '{OP_PUT, 32'h300 + i, 32'h400 + i};
            send_req(r, 0, z);
        end

        // lower capacity below fill level: entries stay, misses evict
        set_capacity(5'd3);
        for (int i = 0; i < 6; i++)
        begin
            r = '{OP_PUT, 32'h500 + i, $urandom()};
            send_req(r, 0, z);
        end

        // back-to-back hits on a single entry
        set_capacity(5'd1);
        r = '{OP_PUT, 32'hABCD, 32'h1};
        send_req(r, 0, z);
        no_idle = 1'b1;
        for (int i = 0; i < 24; i++)
        begin
            r = '{OP_GET, 32'hABCD, 32'h0};
            send_req(r, 0, z);
        end
        no_idle = 1'b0;

        // random phases across capacities
        caps = '{16, 4, 0, 1, 9, 20};
        for (int ph = 0; ph < 6; ph++)
        begin
            set_capacity(caps[ph][CAP_W-1:0]);
            no_idle = (ph == 3);
            for (int i = 0; i < N_RANDOM / 6; i++)
            begin
                r.opcode = 1'($urandom_range(1));
                r.key    = pick_key(caps[ph] + 6);
                r.value  = $urandom();
                send_req(r, 0, z);
            end
        end
        in_valid  <= 1'b0;
        no_idle   = 1'b0;
        stim_done = 1'b1;

        while (rsp_queue.size() != 0)
            @(negedge clk);
        repeat (MAX_ENTRIES + 8)
            @(negedge clk);
        if (fail_count == 0)
            $display("lfu_cache_policy test passed");
        else
            $display("lfu_cache_policy test failed");
        $finish;
    end

endmodule
